// ----- src/lfssr_pkg.sv -----
// package for the line-follow steer and speed regulator
// holds the sequencer state type, register indexes and the exp2 table
`timescale 1ns / 1ps
package lfssr_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_AERR,
    ST_AMUL,
    ST_ASAT,
    ST_CMUL,
    ST_CDIV,
    ST_ECALC,
    ST_POW,
    ST_POWSH,
    ST_LIN,
    ST_FAC,
    ST_REFQ,
    ST_PERR,
    ST_DERR,
    ST_PMUL,
    ST_DMUL,
    ST_DDIV,
    ST_ACC,
    ST_OUT
  } state_t;

  localparam logic [2:0] REG_ANGLE_KP    = 3'd0;
  localparam logic [2:0] REG_ANGLE_ALPHA = 3'd1;
  localparam logic [2:0] REG_SPEED_KP    = 3'd2;
  localparam logic [2:0] REG_SPEED_KD    = 3'd3;
  localparam logic [2:0] REG_SPEED_ALPHA = 3'd4;
  localparam logic [2:0] REG_SPEED_BETA  = 3'd5;
  localparam logic [2:0] REG_ANGLE_THR   = 3'd6;
  localparam logic [2:0] REG_SPEED_THR   = 3'd7;

  // 2^(-2^-(i+1)) in q16 for table index i = 0..15
  function automatic logic [15:0] exp_tab(input logic [3:0] i);
    case (i)
      4'd0:  exp_tab = 16'd46341;
      4'd1:  exp_tab = 16'd55109;
      4'd2:  exp_tab = 16'd60097;
      4'd3:  exp_tab = 16'd62757;
      4'd4:  exp_tab = 16'd64132;
      4'd5:  exp_tab = 16'd64830;
      4'd6:  exp_tab = 16'd65182;
      4'd7:  exp_tab = 16'd65359;
      4'd8:  exp_tab = 16'd65447;
      4'd9:  exp_tab = 16'd65492;
      4'd10: exp_tab = 16'd65514;
      4'd11: exp_tab = 16'd65525;
      4'd12: exp_tab = 16'd65530;
      4'd13: exp_tab = 16'd65533;
      4'd14: exp_tab = 16'd65535;
      default: exp_tab = 16'd65535;
    endcase
  endfunction

endpackage

// ----- src/line_follow_steer_speed_regulator.sv -----
// top level of the line-follow steer and speed regulator
// depends on lfssr_pkg for the state type, register indexes and exp2 table
`timescale 1ns / 1ps
// One word in, one word out. A small sequencer drives one shared signed
// 34 x 34 multiplier and a one-bit-per-cycle restoring divider (49 steps).
// The divider works out the speed-reduction quotient and the division by dt.
// The exp2 product runs 16 table steps through the same multiplier. The
// reduction quotient skips the divide for a magnitude below its threshold,
// a threshold at or above its maximum, or a product so large that the
// quotient saturates. s_tready is high only while the block is idle and no
// result is waiting. The result waits in the output register, and the block
// takes no new word until the result is taken. Log2 of the slope is worked
// out at elaboration.
module line_follow_steer_speed_regulator #(
  parameter int MAX_ANGLE      = 1024,
  parameter int MAX_SPEED      = 1024,
  parameter int SLOPE_Q8       = 512,
  parameter int MIN_FACTOR_Q16 = 16384
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // angle_ref, speed_ref, left_dist, right_dist, meas_speed, dt
  input  logic [95:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // angle_cmd, speed_cmd
  output logic [63:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);
  import lfssr_pkg::*;

  function automatic longint log2_q16(input longint s);
    longint y, n, fr;
    y = s <<< 8; n = 0; fr = 0;
    while (y >= (64'sd2 <<< 16)) begin
      y = y >>> 1; n = n + 1;
    end
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >>> 16;
      fr = fr <<< 1;
      if (y >= (64'sd2 <<< 16)) begin
        y = y >>> 1; fr = fr | 1;
      end
    end
    log2_q16 = (n <<< 16) | fr;
  endfunction

  localparam longint SlopeC = (SLOPE_Q8 < 1) ? 1 : SLOPE_Q8;
  localparam longint LogQ16 = log2_q16(SlopeC);
  localparam longint LinK   = (64'sd1 <<< 24) / SlopeC - MIN_FACTOR_Q16;

  // configuration
  logic signed [15:0] angle_kp, angle_alpha, speed_kp, speed_kd;
  logic signed [15:0] speed_alpha, speed_beta;
  logic [14:0] angle_thr, speed_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_kp <= '0; angle_alpha <= 16'sd256; speed_kp <= '0; speed_kd <= '0;
      speed_alpha <= 16'sd256; speed_beta <= 16'sd256;
      angle_thr <= '0; speed_thr <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ANGLE_KP:    angle_kp <= cfg_wdata;
        REG_ANGLE_ALPHA: angle_alpha <= cfg_wdata;
        REG_SPEED_KP:    speed_kp <= cfg_wdata;
        REG_SPEED_KD:    speed_kd <= cfg_wdata;
        REG_SPEED_ALPHA: speed_alpha <= cfg_wdata;
        REG_SPEED_BETA:  speed_beta <= cfg_wdata;
        REG_ANGLE_THR:   angle_thr <= cfg_wdata[14:0];
        REG_SPEED_THR:   speed_thr <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // captured input word
  logic signed [15:0] angle_ref, speed_ref, curr;
  logic [15:0] dl, dr, dtv;

  state_t state;
  logic signed [31:0] prev_err;
  logic signed [31:0] angle_cmd, speed_cmd;
  logic signed [33:0] acc_a;   // general scratch operands
  logic signed [63:0] prod;    // registered multiplier output
  logic signed [31:0] perr, derr;
  logic signed [49:0] pterm;
  logic [15:0] cval;
  logic [33:0] pw;
  logic [4:0] cnt;
  logic signed [16:0] fac;

  // shared divider: unsigned 49-bit dividend, 34-bit divisor
  logic [48:0] dv_q;
  logic [49:0] dv_r;
  logic [33:0] dv_d;
  logic [5:0]  dv_cnt;
  logic        dv_neg;
  logic [50:0] dv_trial;

  logic signed [32:0] a_abs, s_abs;

  assign dv_trial = {dv_r[49:0], dv_q[48]} - {17'd0, dv_d};
  assign s_tready = (state == ST_IDLE) && !m_tvalid;
  assign m_tdata = {speed_cmd, angle_cmd};

  // operands for the multiplier per state
  logic signed [33:0] op_x, op_y;
  always_comb begin
    op_x = '0; op_y = '0;
    case (state)
      ST_AERR:  begin op_x = 34'(angle_alpha); op_y = 34'(angle_ref); end
      ST_AMUL:  begin op_x = 34'(angle_kp); op_y = acc_a; end
      // denominator of the reduction quotient, lands in the divisor
      ST_ASAT:  begin op_x = 34'(MAX_ANGLE) - 34'(angle_thr);
                      op_y = 34'(MAX_SPEED) - 34'(speed_thr); end
      ST_CMUL:  begin op_x = 34'(a_abs - 33'(angle_thr));
                      op_y = 34'(s_abs - 33'(speed_thr)); end
      ST_ECALC: begin op_x = 34'(cval); op_y = 34'(LogQ16); end
      ST_POW:   begin op_x = 34'(pw); op_y = 34'(exp_tab(cnt[3:0])); end
      ST_LIN:   begin op_x = 34'(cval); op_y = 34'(LinK); end
      ST_REFQ:  begin op_x = 34'(speed_ref); op_y = 34'(fac); end
      ST_PERR:  begin op_x = 34'(speed_alpha); op_y = acc_a; end
      ST_DERR:  begin op_x = 34'(speed_beta); op_y = acc_a; end
      ST_PMUL:  begin op_x = 34'(speed_kp); op_y = 34'(perr); end
      ST_DMUL:  begin op_x = 34'(speed_kd); op_y = 34'(derr) - 34'(prev_err); end
      default: ;
    endcase
  end
  logic signed [67:0] mprod;
  assign mprod = op_x * op_y;

  assign a_abs = angle_cmd[31] ? -33'(angle_cmd) : 33'(angle_cmd);
  assign s_abs = speed_ref[15] ? -33'(speed_ref) : 33'(speed_ref);

  always_ff @(posedge clk) begin : seq_p
    logic signed [63:0] tmp;
    logic [31:0] e_int;
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
      prev_err <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: if (s_tvalid && s_tready) begin
          angle_ref <= s_tdata[15:0]; speed_ref <= s_tdata[31:16];
          dl <= s_tdata[47:32]; dr <= s_tdata[63:48];
          curr <= s_tdata[79:64]; dtv <= s_tdata[95:80];
          state <= ST_AERR;
        end
        ST_AERR: begin
          acc_a <= 34'(mprod) - (34'(dl) <<< 8) + (34'(dr) <<< 8);
          state <= ST_AMUL;
        end
        ST_AMUL: begin prod <= 64'(mprod); state <= ST_ASAT; end
        ST_ASAT: begin
          tmp = prod >>> 16;
          if (tmp > 64'sd2147483647) angle_cmd <= 32'sh7fffffff;
          else if (tmp < -64'sd2147483648) angle_cmd <= 32'sh80000000;
          else angle_cmd <= 32'(tmp);
          dv_d <= 34'(mprod);
          state <= ST_CMUL;
        end
        ST_CMUL: begin
          if (a_abs < 33'(angle_thr) || s_abs < 33'(speed_thr)) begin
            cval <= '0; state <= ST_ECALC;
          end else if (64'(angle_thr) >= MAX_ANGLE || 64'(speed_thr) >= MAX_SPEED) begin
            cval <= 16'd32768; state <= ST_ECALC;
          end else if ($unsigned(mprod) >= 68'(dv_d)) begin
            // quotient reaches one, so it saturates
            cval <= 16'd32768; state <= ST_ECALC;
          end else begin
            dv_q <= {mprod[33:0], 15'd0};
            dv_r <= '0; dv_cnt <= 6'd49;
            state <= ST_CDIV;
          end
        end
        ST_CDIV: begin
          if (dv_trial[50]) begin
            dv_r <= {dv_r[48:0], dv_q[48]}; dv_q <= {dv_q[47:0], 1'b0};
          end else begin
            dv_r <= dv_trial[49:0]; dv_q <= {dv_q[47:0], 1'b1};
          end
          dv_cnt <= dv_cnt - 6'd1;
          if (dv_cnt == 6'd1) begin
            // numerator below the denominator, so the quotient fits 15 bits
            cval <= 16'(dv_trial[50] ? {dv_q[47:0], 1'b0} : {dv_q[47:0], 1'b1});
            state <= ST_ECALC;
          end
        end
        ST_ECALC: begin
          prod <= 64'(mprod) >>> 15;
          pw <= 34'd65536; cnt <= '0;
          state <= ST_POW;
        end
        ST_POW: begin
          if (prod[15 - cnt[3:0]]) pw <= 34'((mprod + 68'sd32768) >>> 16);
          cnt <= cnt + 5'd1;
          if (cnt == 5'd15) state <= ST_POWSH;
        end
        ST_POWSH: begin
          e_int = 32'(prod >>> 16);
          pw <= (e_int >= 32'd17) ? 34'd0 : (pw >> e_int[4:0]);
          state <= ST_LIN;
        end
        ST_LIN: begin
          tmp = 64'(mprod) >>> 15;
          tmp = ($signed(64'(pw)) - tmp) >>> 1;
          if (tmp < 0) fac <= '0;
          else if (tmp > 64'sd32768) fac <= 17'sd32768;
          else fac <= 17'(tmp);
          state <= ST_REFQ;
        end
        ST_FAC: state <= ST_REFQ;
        ST_REFQ: begin acc_a <= 34'(mprod >>> 7); state <= ST_PERR; end
        ST_PERR: begin
          perr <= 32'((mprod >>> 8) - (68'(curr) <<< 8)); state <= ST_DERR;
        end
        ST_DERR: begin
          derr <= 32'((mprod >>> 8) - (68'(curr) <<< 8)); state <= ST_PMUL;
        end
        ST_PMUL: begin
          pterm <= 50'(mprod) + (50'(curr) <<< 16); state <= ST_DMUL;
        end
        ST_DMUL: begin
          // magnitude divide, floor fixed afterwards
          dv_neg <= mprod[67];
          dv_q <= mprod[67] ? 49'(-mprod) : 49'(mprod);
          dv_r <= '0;
          dv_d <= (dtv == 16'd0) ? 34'd1 : 34'(dtv);
          dv_cnt <= 6'd49;
          state <= ST_DDIV;
        end
        ST_DDIV: begin
          if (dv_trial[50]) begin
            dv_r <= {dv_r[48:0], dv_q[48]}; dv_q <= {dv_q[47:0], 1'b0};
          end else begin
            dv_r <= dv_trial[49:0]; dv_q <= {dv_q[47:0], 1'b1};
          end
          dv_cnt <= dv_cnt - 6'd1;
          if (dv_cnt == 6'd1) state <= ST_ACC;
        end
        ST_ACC: begin
          tmp = dv_neg ? -(64'(dv_q) + ((dv_r != '0) ? 64'sd1 : 64'sd0)) : 64'(dv_q);
          tmp = (64'(pterm) + tmp) >>> 16;
          if (tmp > 64'sd2147483647) speed_cmd <= 32'sh7fffffff;
          else if (tmp < -64'sd2147483648) speed_cmd <= 32'sh80000000;
          else speed_cmd <= 32'(tmp);
          prev_err <= derr;
          state <= ST_OUT;
        end
        ST_OUT: begin m_tvalid <= 1'b1; state <= ST_IDLE; end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
